[sv/pefs_pkg.sv]
package pefs_pkg;

    // magnitude width of the distance terms, radius and peak pull
    localparam int UW = 31;
    localparam int SQW = 2 * UW;

    // front end (3) + sqrt + multiply + divide + multiply + divide + output
    localparam int PULL_LAT = 3 + UW + 1 + UW + 1 + UW + 1;

    typedef enum logic [2:0] {
        CFG_FIELD_A_X,
        CFG_FIELD_A_Y,
        CFG_FIELD_B_X,
        CFG_FIELD_B_Y,
        CFG_RADIUS,
        CFG_PEAK_PULL,
        CFG_TIME_STEP
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               last;
    } part_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               last;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [52:0] x);
        logic signed [52:0] hi;
        logic signed [52:0] lo;
        hi = 53'sd2147483647;
        lo = -53'sd2147483648;
        if (x > hi)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (x < lo)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

[sv/pefs_sqrt.sv]
module pefs_sqrt #(
    parameter int NW = 62,
    parameter int TW = 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic [NW-1:0]     radicand,
    input  logic [TW-1:0]     tag_in,
    output logic [NW/2-1:0]   root,
    output logic [TW-1:0]     tag_out
);
    localparam int STAGES = NW / 2;
    localparam logic [NW:0] ONE = 1;

    logic [NW-1:0] n_reg [STAGES];
    logic [NW-1:0] r_reg [STAGES];
    logic [TW-1:0] t_reg [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            localparam logic [NW:0] BIT = ONE << (NW - 2 - 2 * s);
            logic [NW-1:0] n_in;
            logic [NW-1:0] r_in;
            logic [TW-1:0] t_in;
            logic [NW:0]   trial;

            if (s == 0)
            begin : g_first
                assign n_in = radicand;
                assign r_in = '0;
                assign t_in = tag_in;
            end
            else
            begin : g_next
                assign n_in = n_reg[s-1];
                assign r_in = r_reg[s-1];
                assign t_in = t_reg[s-1];
            end

            assign trial = {1'b0, r_in} + BIT;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    t_reg[s] <= t_in;
                    if ({1'b0, n_in} >= trial)
                    begin
                        n_reg[s] <= NW'({1'b0, n_in} - trial);
                        r_reg[s] <= NW'({1'b0, r_in >> 1} + BIT);
                    end
                    else
                    begin
                        n_reg[s] <= n_in;
                        r_reg[s] <= r_in >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root    = r_reg[STAGES-1][NW/2-1:0];
    assign tag_out = t_reg[STAGES-1];

endmodule

[sv/pefs_div.sv]
module pefs_div #(
    parameter int DW = 31,
    parameter int QW = 31,
    parameter int TW = 1
) (
    input  logic                clk,
    input  logic                en,
    input  logic [DW+QW-1:0]    dividend,
    input  logic [DW-1:0]       divisor,
    input  logic [TW-1:0]       tag_in,
    output logic [QW-1:0]       quotient,
    output logic [TW-1:0]       tag_out
);
    // quotient must fit in QW bits; one quotient bit per stage
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] dvs_reg [QW];
    logic [TW-1:0] t_reg   [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] q_in;
            logic [DW-1:0] dvs_in;
            logic [TW-1:0] t_in;
            logic [DW:0]   trial;

            if (s == 0)
            begin : g_first
                assign rem_in = dividend[DW+QW-1:QW];
                assign low_in = dividend[QW-1:0];
                assign q_in   = '0;
                assign dvs_in = divisor;
                assign t_in   = tag_in;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1];
                assign low_in = low_reg[s-1];
                assign q_in   = q_reg[s-1];
                assign dvs_in = dvs_reg[s-1];
                assign t_in   = t_reg[s-1];
            end

            assign trial = {rem_in, low_in[QW-1]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    low_reg[s] <= low_in << 1;
                    dvs_reg[s] <= dvs_in;
                    t_reg[s]   <= t_in;
                    if (trial >= {1'b0, dvs_in})
                    begin
                        rem_reg[s] <= DW'(trial - {1'b0, dvs_in});
                        q_reg[s]   <= {q_in[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s] <= trial[DW-1:0];
                        q_reg[s]   <= {q_in[QW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign quotient = q_reg[QW-1];
    assign tag_out  = t_reg[QW-1];

endmodule

[sv/pefs_delay.sv]
module pefs_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

[sv/pefs_pull.sv]
module pefs_pull (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [31:0]        att_x,
    input  logic signed [31:0]        att_y,
    input  logic signed [31:0]        pos_x,
    input  logic signed [31:0]        pos_y,
    input  logic signed [31:0]        pos_z,
    input  logic [pefs_pkg::UW-1:0]   radius,
    input  logic [pefs_pkg::UW-1:0]   peak_pull,
    output logic signed [31:0]        pull_x,
    output logic signed [31:0]        pull_y
);
    import pefs_pkg::*;

    localparam int STW = 2 * UW + 3;

    logic signed [32:0] dx, dy, dz;
    logic [32:0]        ax, ay, az;
    logic               near;

    logic [UW-1:0]  ux_a_reg, uy_a_reg, uz_a_reg;
    logic           sx_a_reg, sy_a_reg, near_a_reg;

    logic [SQW-1:0] sqx_b_reg, sqy_b_reg, sqz_b_reg, rr_b_reg;
    logic [UW-1:0]  ux_b_reg, uy_b_reg;
    logic           sx_b_reg, sy_b_reg, near_b_reg;

    logic [63:0]    sum;
    logic           ok;
    logic [SQW-1:0] rad_c_reg;
    logic [STW-1:0] tag_c_reg;

    logic [UW-1:0]  d_root;
    logic [STW-1:0] tag_s;
    logic [SQW-1:0] prod_m_reg;
    logic [UW-1:0]  d_m_reg;
    logic [STW-1:0] tag_m_reg;

    logic [UW-1:0]     mag;
    logic [UW+STW-1:0] tag_d;
    logic [UW-1:0]     d_d, ux_d, uy_d;
    logic              sx_d, sy_d, ok_d;

    logic [SQW-1:0] mx_n_reg, my_n_reg;
    logic [UW-1:0]  d_n_reg;
    logic           sx_n_reg, sy_n_reg, ok_n_reg;

    logic [UW-1:0]  qx, qy;
    logic [1:0]     tag_x;
    logic           tag_y;

    logic signed [31:0] pull_x_reg, pull_y_reg;

    assign dx = {att_x[31], att_x} - {pos_x[31], pos_x};
    assign dy = {att_y[31], att_y} - {pos_y[31], pos_y};
    assign dz = 33'sd0 - {pos_z[31], pos_z};
    assign ax = dx[32] ? 33'(-dx) : 33'(dx);
    assign ay = dy[32] ? 33'(-dy) : 33'(dy);
    assign az = dz[32] ? 33'(-dz) : 33'(dz);
    assign near = (ax < {2'b0, radius}) && (ay < {2'b0, radius}) && (az < {2'b0, radius});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_a_reg   <= ax[UW-1:0];
            uy_a_reg   <= ay[UW-1:0];
            uz_a_reg   <= az[UW-1:0];
            sx_a_reg   <= dx[32];
            sy_a_reg   <= dy[32];
            near_a_reg <= near;

            sqx_b_reg  <= ux_a_reg * ux_a_reg;
            sqy_b_reg  <= uy_a_reg * uy_a_reg;
            sqz_b_reg  <= uz_a_reg * uz_a_reg;
            rr_b_reg   <= radius * radius;
            ux_b_reg   <= ux_a_reg;
            uy_b_reg   <= uy_a_reg;
            sx_b_reg   <= sx_a_reg;
            sy_b_reg   <= sy_a_reg;
            near_b_reg <= near_a_reg;

            rad_c_reg  <= ok ? sum[SQW-1:0] : '0;
            tag_c_reg  <= {ux_b_reg, uy_b_reg, sx_b_reg, sy_b_reg, ok};
        end
    end

    assign sum = {2'b0, sqx_b_reg} + {2'b0, sqy_b_reg} + {2'b0, sqz_b_reg};
    assign ok  = near_b_reg && (sum < {2'b0, rr_b_reg}) && (sum != 64'd0);

    pefs_sqrt #(.NW(SQW), .TW(STW)) u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (rad_c_reg),
        .tag_in   (tag_c_reg),
        .root     (d_root),
        .tag_out  (tag_s)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_m_reg <= peak_pull * (radius - d_root);
            d_m_reg    <= d_root;
            tag_m_reg  <= tag_s;
        end
    end

    pefs_div #(.DW(UW), .QW(UW), .TW(UW + STW)) u_div_mag (
        .clk      (clk),
        .en       (en),
        .dividend (prod_m_reg),
        .divisor  (radius),
        .tag_in   ({d_m_reg, tag_m_reg}),
        .quotient (mag),
        .tag_out  (tag_d)
    );

    assign {d_d, ux_d, uy_d, sx_d, sy_d, ok_d} = tag_d;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_n_reg <= mag * ux_d;
            my_n_reg <= mag * uy_d;
            d_n_reg  <= d_d;
            sx_n_reg <= sx_d;
            sy_n_reg <= sy_d;
            ok_n_reg <= ok_d;
        end
    end

    pefs_div #(.DW(UW), .QW(UW), .TW(2)) u_div_x (
        .clk      (clk),
        .en       (en),
        .dividend (mx_n_reg),
        .divisor  (d_n_reg),
        .tag_in   ({sx_n_reg, ok_n_reg}),
        .quotient (qx),
        .tag_out  (tag_x)
    );

    pefs_div #(.DW(UW), .QW(UW), .TW(1)) u_div_y (
        .clk      (clk),
        .en       (en),
        .dividend (my_n_reg),
        .divisor  (d_n_reg),
        .tag_in   (sy_n_reg),
        .quotient (qy),
        .tag_out  (tag_y)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!tag_x[0])
            begin
                pull_x_reg <= '0;
                pull_y_reg <= '0;
            end
            else
            begin
                pull_x_reg <= tag_x[1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
                pull_y_reg <= tag_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            end
        end
    end

    assign pull_x = pull_x_reg;
    assign pull_y = pull_y_reg;

endmodule

[sv/particle_euler_force_field_step.sv]
// Particle Euler step with two attractor fields.
// Input transaction: one particle (position, velocity, force, last_in) on
// in_valid/in_ready. Output transaction: new velocity and position plus
// last_out on out_valid/out_ready, one result per input, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index at the
// clock edge; write only while no particle is in flight.
// Throughput: one particle per cycle while in_ready is high. The result
// path runs through the bit-per-stage square root and then two layers of
// bit-per-stage dividers (magnitude first, then x and y in parallel).
// Stall: the whole pipeline advances together; a result that finds the
// output register full goes to a one-entry skid register, and in_ready
// drops only while the skid register holds a result.
// Reset: clears all valid flags and loads the register defaults
// (attractors at (20,10) and (-5,50), radius 14, peak pull 15, dt 1/100).
module particle_euler_force_field_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_pos_z,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic               last_out
);
    import pefs_pkg::*;

    localparam logic [63:0] DT_RAW = (64'd1 << FRAC_BITS) / 64'd100;
    localparam logic [16:0] DT_RST = (DT_RAW > 64'd131071) ? 17'h1FFFF : DT_RAW[16:0];
    localparam logic [63:0] ONE_Q  = 64'd1 << FRAC_BITS;

    logic signed [31:0] fa_x_reg, fa_y_reg, fb_x_reg, fb_y_reg;
    logic [UW-1:0]      radius_reg, peak_pull_reg;
    logic [16:0]        dt_reg;

    logic               en;
    logic [PULL_LAT-1:0] vld_reg;
    part_t              item_in, item_d;
    logic signed [31:0] pa_x, pa_y, pb_x, pb_y;

    logic               e0_vld_reg, e1_vld_reg, e2_vld_reg, e3_vld_reg;
    logic signed [33:0] fs_reg [3];
    logic signed [51:0] pf_reg [3];
    logic signed [31:0] nv2_reg [3];
    logic signed [31:0] nv3_reg [3];
    logic signed [49:0] pv_reg [3];
    logic signed [31:0] p0_reg [3], p1_reg [3], p2_reg [3], p3_reg [3];
    logic signed [31:0] v0_reg [3], v1_reg [3];
    logic               l0_reg, l1_reg, l2_reg, l3_reg;

    logic signed [17:0] dts;
    logic signed [33:0] fs_next [3];
    logic signed [31:0] nv_next [3];
    logic signed [31:0] np_next [3];
    logic signed [51:0] pf_next [3];
    logic signed [49:0] pv_next [3];
    logic signed [31:0] pin [3], vin [3], fin [3];

    res_t               res_next, out_reg, skid_reg;
    logic               out_vld_reg, skid_vld_reg;
    logic               push, take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_x_reg      <= 32'(64'd20 * ONE_Q);
            fa_y_reg      <= 32'(64'd10 * ONE_Q);
            fb_x_reg      <= -32'(64'd5 * ONE_Q);
            fb_y_reg      <= 32'(64'd50 * ONE_Q);
            radius_reg    <= UW'(64'd14 * ONE_Q);
            peak_pull_reg <= UW'(64'd15 * ONE_Q);
            dt_reg        <= DT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FIELD_A_X: fa_x_reg      <= cfg_data;
                CFG_FIELD_A_Y: fa_y_reg      <= cfg_data;
                CFG_FIELD_B_X: fb_x_reg      <= cfg_data;
                CFG_FIELD_B_Y: fb_y_reg      <= cfg_data;
                CFG_RADIUS:    radius_reg    <= cfg_data[UW-1:0];
                CFG_PEAK_PULL: peak_pull_reg <= cfg_data[UW-1:0];
                CFG_TIME_STEP: dt_reg        <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign en       = !skid_vld_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PULL_LAT-2:0], in_valid};
        end
    end

    assign item_in = '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                       vel_x: vel_x, vel_y: vel_y, vel_z: vel_z,
                       force_x: force_x, force_y: force_y, force_z: force_z,
                       last: last_in};

    pefs_delay #(.W($bits(part_t)), .DEPTH(PULL_LAT)) u_delay (
        .clk  (clk),
        .en   (en),
        .din  (item_in),
        .dout (item_d)
    );

    pefs_pull u_pull_a (
        .clk       (clk),
        .en        (en),
        .att_x     (fa_x_reg),
        .att_y     (fa_y_reg),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .radius    (radius_reg),
        .peak_pull (peak_pull_reg),
        .pull_x    (pa_x),
        .pull_y    (pa_y)
    );

    pefs_pull u_pull_b (
        .clk       (clk),
        .en        (en),
        .att_x     (fb_x_reg),
        .att_y     (fb_y_reg),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .radius    (radius_reg),
        .peak_pull (peak_pull_reg),
        .pull_x    (pb_x),
        .pull_y    (pb_y)
    );

    assign dts = $signed({1'b0, dt_reg});
    assign pin = '{item_d.pos_x, item_d.pos_y, item_d.pos_z};
    assign vin = '{item_d.vel_x, item_d.vel_y, item_d.vel_z};
    assign fin = '{item_d.force_x, item_d.force_y, item_d.force_z};

    always_comb
    begin
        fs_next[0] = {{2{fin[0][31]}}, fin[0]} + {{2{pa_x[31]}}, pa_x}
                   + {{2{pb_x[31]}}, pb_x};
        fs_next[1] = {{2{fin[1][31]}}, fin[1]} + {{2{pa_y[31]}}, pa_y}
                   + {{2{pb_y[31]}}, pb_y};
        fs_next[2] = {{2{fin[2][31]}}, fin[2]};
        for (int i = 0; i < 3; i++)
        begin
            pf_next[i] = dts * fs_reg[i];
            nv_next[i] = sat32({{21{v1_reg[i][31]}}, v1_reg[i]}
                             + {pf_reg[i][51], (pf_reg[i] >>> FRAC_BITS)});
            pv_next[i] = dts * nv2_reg[i];
            np_next[i] = sat32({{21{p3_reg[i][31]}}, p3_reg[i]}
                             + {{3{pv_reg[i][49]}}, (pv_reg[i] >>> FRAC_BITS)});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                fs_reg[i]  <= fs_next[i];
                p0_reg[i]  <= pin[i];
                v0_reg[i]  <= vin[i];
                pf_reg[i]  <= pf_next[i];
                p1_reg[i]  <= p0_reg[i];
                v1_reg[i]  <= v0_reg[i];
                nv2_reg[i] <= nv_next[i];
                p2_reg[i]  <= p1_reg[i];
                pv_reg[i]  <= pv_next[i];
                nv3_reg[i] <= nv2_reg[i];
                p3_reg[i]  <= p2_reg[i];
            end
            l0_reg <= item_d.last;
            l1_reg <= l0_reg;
            l2_reg <= l1_reg;
            l3_reg <= l2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_vld_reg <= 1'b0;
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e0_vld_reg <= vld_reg[PULL_LAT-1];
            e1_vld_reg <= e0_vld_reg;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
        end
    end

    assign res_next = '{pos_x: np_next[0], pos_y: np_next[1], pos_z: np_next[2],
                        vel_x: nv3_reg[0], vel_y: nv3_reg[1], vel_z: nv3_reg[2],
                        last: l3_reg};

    assign push = en && e3_vld_reg;
    assign take = out_vld_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || take)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= push;
            end
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || take)
        begin
            out_reg <= skid_vld_reg ? skid_reg : res_next;
        end
        else if (push)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign new_pos_x = out_reg.pos_x;
    assign new_pos_y = out_reg.pos_y;
    assign new_pos_z = out_reg.pos_z;
    assign new_vel_x = out_reg.vel_x;
    assign new_vel_y = out_reg.vel_y;
    assign new_vel_z = out_reg.vel_z;
    assign last_out  = out_reg.last;

endmodule

[sv/pefs_checker.sv]
module pefs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] new_pos_x,
    input logic signed [31:0] new_pos_y,
    input logic signed [31:0] new_pos_z,
    input logic signed [31:0] new_vel_x,
    input logic signed [31:0] new_vel_y,
    input logic signed [31:0] new_vel_z,
    input logic               last_out
);
    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(new_pos_x) && $stable(new_pos_y)
            && $stable(new_pos_z) && $stable(new_vel_x) && $stable(new_vel_y)
            && $stable(new_vel_z) && $stable(last_out))
        else $error("output changed while stalled");

    // input backpressure only follows an output stall
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("in_ready low without output stall");

    // a completed output transaction frees the skid slot
    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready)
        else $error("in_ready low after output transaction");

    // no output transaction appears out of an empty pipe on the first cycle
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("out_valid at reset release");

endmodule

bind particle_euler_force_field_step pefs_checker u_pefs_checker (.*);

[tb/sv/particle_euler_force_field_step_test.sv]
`timescale 1ns / 100ps

module particle_euler_force_field_step_test;
    import pefs_pkg::*;

    typedef struct {
        longint px, py, pz, vx, vy, vz;
        bit     last;
    } step_out_t;

    class step_scoreboard;
        step_out_t pending[$];
        int        mismatches;
        longint    att_ax, att_ay, att_bx, att_by;
        longint    reach, pull_max, dt;

        function void set_defaults();
            att_ax = 20 <<< 16;
            att_ay = 10 <<< 16;
            att_bx = -(5 <<< 16);
            att_by = 50 <<< 16;
            reach = 14 <<< 16;
            pull_max = 15 <<< 16;
            dt = 655;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] d);
            case (idx)
                CFG_FIELD_A_X: att_ax = longint'(signed'(d));
                CFG_FIELD_A_Y: att_ay = longint'(signed'(d));
                CFG_FIELD_B_X: att_bx = longint'(signed'(d));
                CFG_FIELD_B_Y: att_by = longint'(signed'(d));
                CFG_RADIUS: reach = longint'(d[30:0]);
                CFG_PEAK_PULL: pull_max = longint'(d[30:0]);
                CFG_TIME_STEP: dt = longint'(d[16:0]);
                default: ;
            endcase
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint dt_mul(longint v);
            return (dt * v) >>> 16;
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
            begin
                b >>= 2;
            end
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void attract(longint ax, longint ay, longint px, longint py,
                              longint pz, inout longint fx, inout longint fy);
            longint dx, dy, dz;
            longint unsigned ux, uy, uz, r, s, d, mag, cx, cy;
            dx = ax - px;
            dy = ay - py;
            dz = -pz;
            ux = dx < 0 ? -dx : dx;
            uy = dy < 0 ? -dy : dy;
            uz = dz < 0 ? -dz : dz;
            r = reach;
            if (ux >= r || uy >= r || uz >= r)
            begin
                return;
            end
            s = ux * ux + uy * uy + uz * uz;
            if (s >= r * r || s == 0)
            begin
                return;
            end
            d = root(s);
            mag = (pull_max * (r - d)) / r;
            cx = (mag * ux) / d;
            cy = (mag * uy) / d;
            fx += dx < 0 ? -longint'(cx) : longint'(cx);
            fy += dy < 0 ? -longint'(cy) : longint'(cy);
        endfunction

        function void note_particle(part_t p);
            longint fx, fy, fz;
            step_out_t e;
            fx = p.force_x;
            fy = p.force_y;
            fz = p.force_z;
            attract(att_ax, att_ay, p.pos_x, p.pos_y, p.pos_z, fx, fy);
            attract(att_bx, att_by, p.pos_x, p.pos_y, p.pos_z, fx, fy);
            e.vx = sat(longint'(p.vel_x) + dt_mul(fx));
            e.vy = sat(longint'(p.vel_y) + dt_mul(fy));
            e.vz = sat(longint'(p.vel_z) + dt_mul(fz));
            e.px = sat(longint'(p.pos_x) + dt_mul(e.vx));
            e.py = sat(longint'(p.pos_y) + dt_mul(e.vy));
            e.pz = sat(longint'(p.pos_z) + dt_mul(e.vz));
            e.last = p.last;
            pending.push_back(e);
        endfunction

        function void check_result(res_t r);
            step_out_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result transaction %p", r);
                end
                return;
            end
            e = pending.pop_front();
            if (longint'(r.pos_x) != e.px || longint'(r.pos_y) != e.py ||
                longint'(r.pos_z) != e.pz || longint'(r.vel_x) != e.vx ||
                longint'(r.vel_y) != e.vy || longint'(r.vel_z) != e.vz ||
                r.last != e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: exp p=%0d,%0d,%0d v=%0d,%0d,%0d l=%0d",
                             e.px, e.py, e.pz, e.vx, e.vy, e.vz, e.last);
                    $display("          got p=%0d,%0d,%0d v=%0d,%0d,%0d l=%0d",
                             r.pos_x, r.pos_y, r.pos_z, r.vel_x, r.vel_y,
                             r.vel_z, r.last);
                end
            end
        endfunction
    endclass

    logic clk, rst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    part_t item;
    res_t res;

    step_scoreboard sb;
    int  sent, received, idle_cycles;
    bit  idle_off, hold_rx, timed_out;

    particle_euler_force_field_step dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(item.pos_x), .pos_y(item.pos_y), .pos_z(item.pos_z),
        .vel_x(item.vel_x), .vel_y(item.vel_y), .vel_z(item.vel_z),
        .force_x(item.force_x), .force_y(item.force_y), .force_z(item.force_z),
        .last_in(item.last), .out_valid(out_valid), .out_ready(out_ready),
        .new_pos_x(res.pos_x), .new_pos_y(res.pos_y), .new_pos_z(res.pos_z),
        .new_vel_x(res.vel_x), .new_vel_y(res.vel_y), .new_vel_z(res.vel_z),
        .last_out(res.last)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(res);
            received++;
        end
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_particle(item);
            sent++;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles > 5000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !hold_rx && (idle_off || $urandom_range(99) >= 20);
        end
    end

    function automatic logic [31:0] pick_coord(logic signed [31:0] near);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            3: return near;
            default: return near + $signed($urandom_range(2 * 1048576) - 1048576);
        endcase
    endfunction

    function automatic part_t rand_particle();
        part_t p;
        logic signed [31:0] ax, ay;
        ax = $urandom_range(1) ? 32'(sb.att_ax) : 32'(sb.att_bx);
        ay = $urandom_range(1) ? 32'(sb.att_ay) : 32'(sb.att_by);
        p.pos_x = pick_coord(ax);
        p.pos_y = pick_coord(ay);
        p.pos_z = pick_coord(0);
        p.vel_x = pick_coord(0);
        p.vel_y = pick_coord(0);
        p.vel_z = pick_coord(0);
        p.force_x = pick_coord(0);
        p.force_y = pick_coord(0);
        p.force_z = pick_coord(0);
        p.last = 1'($urandom_range(1));
        return p;
    endfunction

    task automatic send_particle(part_t p);
        while (!idle_off && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (120) @(posedge clk);
    endtask

    task automatic run_random(int n);
        repeat (n)
        begin
            send_particle(rand_particle());
        end
        drain();
    endtask

    initial
    begin
        part_t p;
        sb = new();
        sb.set_defaults();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        in_valid = 0;
        item = '0;
        hold_rx = 0;
        idle_off = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        p = '0;
        send_particle(p);
        p.pos_x = 32'(sb.att_ax); p.pos_y = 32'(sb.att_ay);
        send_particle(p);
        p.pos_x = 32'(sb.att_ax - 65536); p.last = 1'b1;
        send_particle(p);
        p.pos_x = 32'(sb.att_ax + 3 * 65536); p.pos_y = 32'(sb.att_ay - 65536);
        p.pos_z = 2 * 65536;
        send_particle(p);
        p.pos_x = 32'(sb.att_ax + 14 * 65536); p.pos_y = 32'(sb.att_ay); p.pos_z = 0;
        send_particle(p);
        p.pos_x = 32'(sb.att_ax + 14 * 65536 - 1);
        send_particle(p);
        p.pos_x = 32'(sb.att_bx); p.pos_y = 32'(sb.att_by + 65536); p.pos_z = -65536;
        send_particle(p);
        p = '1;
        send_particle(p);
        p.pos_x = 32'h7FFFFFFF; p.pos_y = 32'h7FFFFFFF; p.pos_z = 32'h7FFFFFFF;
        p.vel_x = 32'h7FFFFFFF; p.vel_y = 32'h80000000; p.vel_z = 32'h7FFFFFFF;
        p.force_x = 32'h7FFFFFFF; p.force_y = 32'h80000000;
        p.force_z = 32'h80000000; p.last = 1'b0;
        send_particle(p);
        p.pos_x = 32'h80000000; p.pos_y = 32'h80000000; p.pos_z = 32'h80000000;
        p.vel_x = 32'h80000000; p.vel_z = 32'h80000000;
        send_particle(p);
        drain();

        write_reg(CFG_TIME_STEP, 32'h10000);
        write_reg(CFG_PEAK_PULL, 32'h7FFFFFFF);
        write_reg(CFG_RADIUS, 32'h7FFFFFFF);
        write_reg(CFG_FIELD_A_X, 32'h7FFFFFFF);
        write_reg(CFG_FIELD_A_Y, 32'h80000000);
        write_reg(CFG_FIELD_B_X, 32'h0);
        write_reg(CFG_FIELD_B_Y, 32'h0);
        run_random(200);

        write_reg(CFG_RADIUS, 32'h10000);
        write_reg(CFG_PEAK_PULL, 32'h0);
        write_reg(CFG_TIME_STEP, 32'h0);
        run_random(150);

        write_reg(CFG_FIELD_A_X, $urandom);
        write_reg(CFG_FIELD_A_Y, $urandom);
        write_reg(CFG_FIELD_B_X, $urandom_range(20 << 16) - (10 << 16));
        write_reg(CFG_FIELD_B_Y, $urandom_range(20 << 16) - (10 << 16));
        write_reg(CFG_RADIUS, $urandom_range(32'h7FFFFFFF, 32'h10000));
        write_reg(CFG_PEAK_PULL, $urandom_range(32'h7FFFFFFF));
        write_reg(CFG_TIME_STEP, $urandom_range(32'h1FFFF));
        fork
            begin
                hold_rx = 1;
                repeat (400) @(posedge clk);
                hold_rx = 0;
            end
            run_random(300);
        join

        write_reg(CFG_FIELD_A_X, 20 << 16);
        write_reg(CFG_FIELD_A_Y, 10 << 16);
        write_reg(CFG_FIELD_B_X, -(5 << 16));
        write_reg(CFG_FIELD_B_Y, 50 << 16);
        write_reg(CFG_RADIUS, 14 << 16);
        write_reg(CFG_PEAK_PULL, 15 << 16);
        write_reg(CFG_TIME_STEP, 655);
        idle_off = 1;
        run_random(250);
        idle_off = 0;
        run_random(340);

        $display("Stepped %0d particles (%0d results) over five register settings,",
                 sent, received);
        $display("with random stalls on both channels and one long output hold-off.");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("mismatches: %0d, left over: %0d", sb.mismatches,
                     sb.pending.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
